// ===== src/brace_hex_escape_codec_defines.svh =====
// Assertion macros shared by the checker of the escape codec.
`ifndef BRACE_HEX_ESCAPE_CODEC_DEFINES_SVH
`define BRACE_HEX_ESCAPE_CODEC_DEFINES_SVH

// Concurrent assertion that is switched off while reset is asserted.
`define BHE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked while reset is asserted.
`define BHE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== src/bhe_pkg.sv =====
// Types, constants and helper functions of the brace hex escape codec.
`default_nettype none
package bhe_pkg;

  localparam logic [7:0] OPEN_MARK  = 8'h7B;
  localparam logic [7:0] CLOSE_MARK = 8'h7D;
  localparam logic [7:0] PRINT_LO   = 8'h20;
  localparam logic [7:0] PRINT_HI   = 8'h7E;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_F     = 8'h46;
  localparam logic [3:0] NIB_TEN    = 4'd10;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_message;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       is_error;
    logic       last_of_run;
  } out_word_t;

  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      last_idx;
    logic            is_err;
  } job_t;

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib >= NIB_TEN) begin
      c = CHAR_A + {4'd0, nib - NIB_TEN};
    end else begin
      c = CHAR_ZERO + {4'd0, nib};
    end
    return c;
  endfunction

  // Bit 4 set means the byte is not an upper-case hex digit.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] d;
    logic [4:0] v;
    d = 8'd0;
    v = 5'h10;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d = c - CHAR_ZERO;
      v = {1'b0, d[3:0]};
    end else if (c >= CHAR_A && c <= CHAR_F) begin
      d = c - CHAR_A + {4'd0, NIB_TEN};
      v = {1'b0, d[3:0]};
    end
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== src/bhe_front.sv =====
// Front end: accepts input words, tracks decode state and builds result jobs.
`default_nettype none
module bhe_front
  import bhe_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     direction,
  input  wire logic     in_valid,
  input  wire in_word_t in_data,
  input  wire logic     q_full,
  output logic          in_ready,
  output logic          push,
  output job_t          push_job
);

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_OPEN  = 2'd1;
  localparam logic [1:0] PH_DIGIT = 2'd2;
  localparam logic [1:0] PH_CLOSE = 2'd3;

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] part_r, part_nxt;
  logic       drop_r, drop_nxt;

  logic       accept;
  logic       want;
  logic       err;
  logic [7:0] b;
  logic       eom;
  logic [4:0] v;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign b        = in_data.data_byte;
  assign eom      = in_data.end_of_message;
  assign v        = hex_value(b);
  assign push     = accept && want;

  always_comb begin
    phase_nxt         = phase_r;
    part_nxt          = part_r;
    drop_nxt          = drop_r;
    want              = 1'b0;
    err               = 1'b0;
    push_job.bytes    = {4{b}};
    push_job.last_idx = 2'd0;
    push_job.is_err   = 1'b0;
    if (direction == DIR_ENCODE) begin
      want = 1'b1;
      if (b == OPEN_MARK) begin
        push_job.bytes    = {8'd0, 8'd0, OPEN_MARK, OPEN_MARK};
        push_job.last_idx = 2'd1;
      end else if (b >= PRINT_LO && b <= PRINT_HI) begin
        push_job.last_idx = 2'd0;
      end else begin
        push_job.bytes    = {CLOSE_MARK, hex_char(b[3:0]), hex_char(b[7:4]), OPEN_MARK};
        push_job.last_idx = 2'd3;
      end
    end else if (drop_r) begin
      if (eom) begin
        drop_nxt = 1'b0;
      end
    end else begin
      case (phase_r)
        PH_IDLE: begin
          if (b == OPEN_MARK) begin
            phase_nxt = PH_OPEN;
          end else begin
            want = 1'b1;
          end
        end
        PH_OPEN: begin
          if (b == OPEN_MARK) begin
            want      = 1'b1;
            phase_nxt = PH_IDLE;
          end else if (!v[4]) begin
            part_nxt  = {4'd0, v[3:0]};
            phase_nxt = PH_DIGIT;
          end else begin
            err = 1'b1;
          end
        end
        PH_DIGIT: begin
          if (!v[4]) begin
            part_nxt  = {part_r[3:0], v[3:0]};
            phase_nxt = PH_CLOSE;
          end else begin
            err = 1'b1;
          end
        end
        PH_CLOSE: begin
          if (b == CLOSE_MARK) begin
            want           = 1'b1;
            push_job.bytes = {4{part_r}};
            phase_nxt      = PH_IDLE;
          end else begin
            err = 1'b1;
          end
        end
        default: begin
          err = 1'b1;
        end
      endcase
      if (eom && phase_nxt != PH_IDLE) begin
        err = 1'b1;
      end
      if (err) begin
        want              = 1'b1;
        push_job.bytes    = '0;
        push_job.last_idx = 2'd0;
        push_job.is_err   = 1'b1;
        phase_nxt         = PH_IDLE;
        part_nxt          = 8'd0;
        drop_nxt          = !eom;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      part_r  <= 8'd0;
      drop_r  <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      part_r  <= part_nxt;
      drop_r  <= drop_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/bhe_queue.sv =====
// Job queue between the front end and the back end.
`default_nettype none
module bhe_queue
  import bhe_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output logic      q_full,
  output logic      q_valid,
  output job_t      head_job
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_pop;

  assign q_full   = (count_r == CNT_W'(DEPTH));
  assign q_valid  = (count_r != '0);
  assign head_job = mem[rd_ptr_r];
  assign do_pop   = pop && q_valid;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/bhe_back.sv =====
// Back end: walks the head job and emits one result word per cycle unless stalled.
`default_nettype none
module bhe_back
  import bhe_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_valid,
  input  wire job_t head_job,
  input  wire logic out_ready,
  output logic      pop,
  output logic      out_valid,
  output out_word_t out_data
);

  logic [1:0] idx_r, idx_nxt;
  logic       out_valid_r, out_valid_nxt;
  out_word_t  out_data_r, out_data_nxt;
  logic       load;
  logic       is_last;

  assign load      = !out_valid_r || out_ready;
  assign is_last   = (idx_r == head_job.last_idx);
  assign pop       = load && q_valid && is_last;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (load) begin
      out_valid_nxt            = q_valid;
      out_data_nxt.out_byte    = head_job.bytes[idx_r];
      out_data_nxt.is_error    = head_job.is_err;
      out_data_nxt.last_of_run = is_last;
      if (q_valid) begin
        idx_nxt = is_last ? 2'd0 : idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== src/brace_hex_escape_codec.sv =====
// Top level of the brace hex escape codec.
// Each input word is classified and turned into a job of one to four result words,
// or none, in the cycle it is accepted, and the job waits in a queue of QUEUE_DEPTH
// entries; the back end sends one result word per cycle from its output register while
// the queue holds a job and the output is not stalled, so a word that yields several
// results holds the output until each is sent (four for an encoded non-printable byte).
// The first result passes through the queue and then the output register, and input
// words are taken whenever the queue has room, also while the output stalls.
// The direction register is meant to be written only while the block is idle.
`default_nettype none
module brace_hex_escape_codec
  import bhe_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cfg_we,
  input  wire logic     cfg_wdata,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire in_word_t in_data,
  output logic          out_valid,
  input  wire logic     out_ready,
  output out_word_t     out_data
);

  logic direction_r;
  logic q_full;
  logic q_valid;
  logic push;
  logic pop;
  job_t push_job;
  job_t head_job;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= DIR_ENCODE;
    end else if (cfg_we) begin
      direction_r <= cfg_wdata;
    end
  end

  bhe_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .direction (direction_r),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .q_full    (q_full),
    .in_ready  (in_ready),
    .push      (push),
    .push_job  (push_job)
  );

  bhe_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_full   (q_full),
    .q_valid  (q_valid),
    .head_job (head_job)
  );

  bhe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .head_job  (head_job),
    .out_ready (out_ready),
    .pop       (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

// ===== src/bhe_checker.sv =====
// Port-level checker of the escape codec and its bind to the top level.
`default_nettype none
`include "brace_hex_escape_codec_defines.svh"
module bhe_checker
  import bhe_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_ready,
  input wire out_word_t out_data
);

  `BHE_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_data), "result word changed while stalled")
  `BHE_ASSERT(a_err_shape, out_valid && out_data.is_error |-> out_data.out_byte == 8'd0 && out_data.last_of_run, "malformed error word")
  `BHE_ASSERT(a_run_cont, out_valid && out_ready && !out_data.last_of_run |=> out_valid, "gap inside a run of results")
  `BHE_ASSERT_ALWAYS(a_reset_quiet, !rst_n |=> !out_valid, "result valid right after reset")

endmodule

bind brace_hex_escape_codec bhe_checker u_bhe_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire
